### design/modulated_delay_feedback_effect_core_assert.svh
// assertion macros shared by the flanger core rtl
// no dependencies; included by the modules that carry assertions
`ifndef MODULATED_DELAY_FEEDBACK_EFFECT_CORE_ASSERT_SVH
`define MODULATED_DELAY_FEEDBACK_EFFECT_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MDFE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MDFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mdfe_pkg.sv
// shared types, constants, microprogram and sine table function of the flanger core
// no dependencies
package mdfe_pkg;

   // field and datapath widths
   localparam int ADC_W      = 12;
   localparam int ADC_HI_W   = 4;
   localparam int ADC_LO_W   = ADC_W - ADC_HI_W;
   localparam int PWM_W      = 8;
   localparam int SMP_W      = 16;
   localparam int PHASE_W    = 24;
   localparam int GAIN_W     = 15;
   localparam int SINE_W     = 15;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int SUM_W      = 18;
   localparam int MOD_W      = 31;
   localparam int Q_FRAC     = 15;
   localparam int DELAY_SHIFT = 31;
   localparam int LEVEL_SHIFT = 16;
   localparam int LEVEL_W    = 9;
   localparam int PC_W       = 4;
   localparam int PROG_LEN   = 14;

   // arithmetic constants
   localparam logic [ADC_W:0]              ADC_FULL    = 13'd4095;
   localparam logic signed [SMP_W-1:0]     SMP_MAX     = 16'sh7fff;
   localparam logic signed [SMP_W-1:0]     SMP_MIN     = 16'sh8000;
   localparam logic signed [SUM_W-1:0]     OUT_BIAS    = 18'sd32768;
   localparam logic signed [PROD_W-1:0]    MOD_OFFSET  = 48'sd1073741824;
   localparam logic signed [MUL_B_W-1:0]   LEVEL_SCALE = 16'sd255;

   // register file
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LFO_STEP      = 2'd0,
      CSR_MOD_DEPTH     = 2'd1,
      CSR_FEEDBACK_GAIN = 2'd2,
      CSR_WET_GAIN      = 2'd3
   } mdfe_csr_idx_type;

   typedef struct packed {
      logic [PHASE_W-1:0] lfo_step;
      logic [GAIN_W-1:0]  mod_depth;
      logic [GAIN_W-1:0]  feedback_gain;
      logic [GAIN_W-1:0]  wet_gain;
   } mdfe_csr_type;

   localparam mdfe_csr_type CSR_RST = '{
      lfo_step:      24'd190,
      mod_depth:     15'd16384,
      feedback_gain: 15'd22938,
      wet_gain:      15'd22938
   };

   // micro-operations of the datapath
   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_ACCEPT    = 4'd1,
      OP_SINE      = 4'd2,
      OP_MUL_SINE  = 4'd3,
      OP_OFFSET    = 4'd4,
      OP_MUL_DEPTH = 4'd5,
      OP_ADDR      = 4'd6,
      OP_READ      = 4'd7,
      OP_MUL_FB    = 4'd8,
      OP_WRITE     = 4'd9,
      OP_MUL_WET   = 4'd10,
      OP_SUM       = 4'd11,
      OP_MUL_LEVEL = 4'd12,
      OP_OUT       = 4'd13
   } mdfe_op_type;

   typedef enum logic [1:0] {
      COND_NONE     = 2'd0,
      COND_ALWAYS   = 2'd1,
      COND_NO_REQ   = 2'd2,
      COND_OUT_BUSY = 2'd3
   } mdfe_cond_type;

   typedef struct packed {
      mdfe_op_type      op;
      mdfe_cond_type    cond;
      logic [PC_W-1:0]  target;
   } mdfe_uword_type;

   typedef struct packed {
      mdfe_op_type op;
   } mdfe_ctrl_type;

   typedef struct packed {
      logic clear_busy;
      logic out_busy;
   } mdfe_status_type;

   localparam logic [PC_W-1:0] STEP_ACCEPT   = 4'd0;
   localparam logic [PC_W-1:0] STEP_SINE     = 4'd1;
   localparam logic [PC_W-1:0] STEP_OUT_WAIT = 4'd12;

   // one control word per step
   localparam mdfe_uword_type PROGRAM [PROG_LEN] = '{
      '{OP_ACCEPT,    COND_NO_REQ,   STEP_ACCEPT},
      '{OP_SINE,      COND_NONE,     STEP_ACCEPT},
      '{OP_MUL_SINE,  COND_NONE,     STEP_ACCEPT},
      '{OP_OFFSET,    COND_NONE,     STEP_ACCEPT},
      '{OP_MUL_DEPTH, COND_NONE,     STEP_ACCEPT},
      '{OP_ADDR,      COND_NONE,     STEP_ACCEPT},
      '{OP_READ,      COND_NONE,     STEP_ACCEPT},
      '{OP_MUL_FB,    COND_NONE,     STEP_ACCEPT},
      '{OP_WRITE,     COND_NONE,     STEP_ACCEPT},
      '{OP_MUL_WET,   COND_NONE,     STEP_ACCEPT},
      '{OP_SUM,       COND_NONE,     STEP_ACCEPT},
      '{OP_MUL_LEVEL, COND_NONE,     STEP_ACCEPT},
      '{OP_NOP,       COND_OUT_BUSY, STEP_OUT_WAIT},
      '{OP_OUT,       COND_ALWAYS,   STEP_ACCEPT}
   };

   // quarter-wave sine table, evaluated at elaboration only
   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam longint ONE_Q30      = 64'sd1073741824;
   localparam longint SINE_PEAK    = 64'sd32767;
   localparam int     TAYLOR_TERMS = 8;
   localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};

   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned qbits);
      longint a;
      longint term;
      longint sum;
      longint v;
      a    = (HALF_PI_Q30 * longint'(k)) >>> qbits;
      term = a;
      sum  = a;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
         term = (term * a) / ONE_Q30;
         term = (term * a) / ONE_Q30;
         term = -term / TAYLOR_DIV[n];
         sum  = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum * SINE_PEAK + ONE_Q30 / 2) / ONE_Q30;
      if (v > SINE_PEAK) begin
         v = SINE_PEAK;
      end
      return SINE_W'(v);
   endfunction

endpackage

### design/mdfe_if.sv
// sample and level channel interfaces of the flanger core
// depends on mdfe_pkg
interface mdfe_req_if;
   import mdfe_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADC_W-1:0]  adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface mdfe_rsp_if;
   import mdfe_pkg::*;
   logic              valid;
   logic              ready;
   logic [PWM_W-1:0]  pwm_level;
   modport source (output valid, output pwm_level, input ready);
   modport sink   (input valid, input pwm_level, output ready);
endinterface

### design/mdfe_seq.sv
// microprogram sequencer: step counter, control store and conditional jumps
// depends on mdfe_pkg and the assertion macro header
`include "modulated_delay_feedback_effect_core_assert.svh"

module mdfe_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mdfe_pkg::mdfe_status_type status,
   output mdfe_pkg::mdfe_ctrl_type   ctrl
);
   import mdfe_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   mdfe_uword_type  word;
   logic            accept;
   logic            jump;
   logic            hold;

   assign word      = PROGRAM[pc_ff];
   assign req_ready = (pc_ff == STEP_ACCEPT) && !status.clear_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      jump = 1'b0;
      unique case (word.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !accept;
         COND_OUT_BUSY: jump = status.out_busy;
      endcase
      // waiting steps issue no operation
      hold    = jump && (word.cond != COND_ALWAYS);
      pc_in   = jump ? word.target : pc_ff + 1'b1;
      ctrl.op = hold ? OP_NOP : word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `MDFE_ASSERT_IMPLIES(a_clear_parks_seq, clock, reset, status.clear_busy, pc_ff == STEP_ACCEPT, "sequencer left start during clear")
   `MDFE_ASSERT_IMPLIES(a_out_when_free, clock, reset, ctrl.op == OP_OUT, !status.out_busy, "result loaded over an untaken one")
   `MDFE_ASSERT_NEXT(a_accept_advances, clock, reset, accept, pc_ff == STEP_SINE, "accepted transaction did not start the program")
   `MDFE_ASSERT_IMPLIES(a_pc_in_program, clock, reset, 1'b1, pc_ff < PC_W'(PROG_LEN), "step counter outside the program")

endmodule

### design/mdfe_dp.sv
// flanger datapath: shared multiplier, lfo, sine table, delay memory, output register
// depends on mdfe_pkg
module mdfe_dp #(
   parameter int DELAY_DEPTH     = 88,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mdfe_pkg::mdfe_ctrl_type            ctrl,
   input  mdfe_pkg::mdfe_csr_type             csr,
   input  logic [mdfe_pkg::ADC_W-1:0]         req_adc_sample,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [mdfe_pkg::PWM_W-1:0]         rsp_pwm_level,
   output mdfe_pkg::mdfe_status_type          status
);
   import mdfe_pkg::*;

   localparam int PTR_W = $clog2(DELAY_DEPTH);
   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QLEN  = 1 << QBITS;

   // constant quarter sine table
   logic [SINE_W-1:0] sine_rom [QLEN+1];
   for (genvar gk = 0; gk <= QLEN; gk++) begin : g_sine
      assign sine_rom[gk] = quarter_sine(gk, QBITS);
   end

   logic [SMP_W-1:0] delay_mem [DELAY_DEPTH];

   // control registers
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic               clr_busy_ff, clr_busy_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SMP_W-1:0]  x_ff, x_in;
   logic signed [SMP_W-1:0]  sine_ff, sine_in;
   logic [MOD_W-1:0]         mod_ff, mod_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PTR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic signed [SMP_W-1:0]  delayed_ff;
   logic signed [SUM_W-1:0]  y_ff, y_in;
   logic [PWM_W-1:0]         pwm_ff, pwm_in;

   // input mapping
   logic [ADC_HI_W-1:0]     adc_hi;
   logic [ADC_W:0]          map_rem;
   logic [ADC_HI_W:0]       map_quo;
   logic [SMP_W:0]          map_scaled;
   logic signed [SMP_W-1:0] x_map;

   // sine lookup
   logic [SINE_TABLE_BITS-1:0] sine_idx;
   logic [QBITS:0]             rom_idx;
   logic signed [SMP_W-1:0]    sine_pos;
   logic signed [SMP_W-1:0]    sine_val;

   // shared multiplier and misc
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mod_sum;
   logic [PTR_W-1:0]          delay_raw;
   logic [PTR_W-1:0]          delay_lim;
   logic [PTR_W:0]            rd_diff;
   logic signed [SUM_W-1:0]   gain_term;
   logic signed [SUM_W-1:0]   wr_sum;
   logic [SMP_W-1:0]          wr_data;
   logic [LEVEL_W-1:0]        level;

   // adc*65536/4095 = 16*adc + floor(16*adc/4095), one correction step
   always_comb begin
      adc_hi     = req_adc_sample[ADC_W-1 -: ADC_HI_W];
      map_rem    = {1'b0, req_adc_sample[ADC_LO_W-1:0], {(SMP_W-ADC_W){1'b0}}}
                   + (ADC_W+1)'(adc_hi);
      map_quo    = {1'b0, adc_hi} + (ADC_HI_W+1)'(map_rem >= ADC_FULL);
      map_scaled = {1'b0, req_adc_sample, {(SMP_W-ADC_W){1'b0}}} + (SMP_W+1)'(map_quo);
      x_map      = map_scaled[SMP_W] ? SMP_MAX : {~map_scaled[SMP_W-1], map_scaled[SMP_W-2:0]};
   end

   // quadrant mirror and negate
   always_comb begin
      sine_idx = phase_ff[PHASE_W-1 -: SINE_TABLE_BITS];
      rom_idx  = sine_idx[SINE_TABLE_BITS-2] ?
                 ((QBITS+1)'(QLEN) - {1'b0, sine_idx[QBITS-1:0]}) :
                 {1'b0, sine_idx[QBITS-1:0]};
      sine_pos = {1'b0, sine_rom[rom_idx]};
      sine_val = sine_idx[SINE_TABLE_BITS-1] ? -sine_pos : sine_pos;
   end

   // delay and read address
   always_comb begin
      mod_sum   = prod_ff + MOD_OFFSET;
      delay_raw = prod_ff[DELAY_SHIFT +: PTR_W];
      delay_lim = ({1'b0, delay_raw} >= (PTR_W+1)'(DELAY_DEPTH)) ?
                  PTR_W'(DELAY_DEPTH - 1) : delay_raw;
      rd_diff   = {1'b0, wp_ff} - {1'b0, delay_lim};
   end

   // gain product scaled back to q1.15, saturated write value
   always_comb begin
      gain_term = SUM_W'(prod_ff >>> Q_FRAC);
      wr_sum    = SUM_W'(x_ff) + gain_term;
      if ((wr_sum[SUM_W-1:SMP_W-1] == '0) || (wr_sum[SUM_W-1:SMP_W-1] == '1)) begin
         wr_data = wr_sum[SMP_W-1:0];
      end else begin
         wr_data = wr_sum[SUM_W-1] ? SMP_MIN : SMP_MAX;
      end
      level = prod_ff[LEVEL_SHIFT +: LEVEL_W];
   end

   always_comb begin
      phase_in     = phase_ff;
      wp_in        = wp_ff;
      x_in         = x_ff;
      sine_in      = sine_ff;
      mod_in       = mod_ff;
      rd_addr_in   = rd_addr_ff;
      y_in         = y_ff;
      pwm_in       = pwm_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_ACCEPT: begin
            x_in     = x_map;
            phase_in = phase_ff + csr.lfo_step;
         end
         OP_SINE: begin
            sine_in = sine_val;
         end
         OP_MUL_SINE: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(sine_ff);
            mul_b  = MUL_B_W'(csr.mod_depth);
         end
         OP_OFFSET: begin
            mod_in = mod_sum[MOD_W-1:0];
         end
         OP_MUL_DEPTH: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(mod_ff);
            mul_b  = MUL_B_W'(DELAY_DEPTH);
         end
         OP_ADDR: begin
            rd_addr_in = rd_diff[PTR_W] ? PTR_W'(rd_diff + (PTR_W+1)'(DELAY_DEPTH)) :
                         rd_diff[PTR_W-1:0];
         end
         OP_READ: begin
         end
         OP_MUL_FB: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(delayed_ff);
            mul_b  = MUL_B_W'(csr.feedback_gain);
         end
         OP_WRITE: begin
            wp_in = (wp_ff == PTR_W'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         OP_MUL_WET: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(delayed_ff);
            mul_b  = MUL_B_W'(csr.wet_gain);
         end
         OP_SUM: begin
            y_in = SUM_W'(x_ff) + gain_term + OUT_BIAS;
         end
         OP_MUL_LEVEL: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_W'(y_ff);
            mul_b  = LEVEL_SCALE;
         end
         OP_OUT: begin
            if (y_ff[SUM_W-1] || (y_ff == '0)) begin
               pwm_in = '0;
            end else begin
               pwm_in = level[LEVEL_W-1] ? '1 : level[PWM_W-1:0];
            end
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   // clearing pass over the delay memory after reset
   always_comb begin
      clr_ptr_in  = clr_ptr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == PTR_W'(DELAY_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         wp_ff        <= '0;
         clr_ptr_ff   <= '0;
         clr_busy_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_busy_ff  <= clr_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      sine_ff    <= sine_in;
      mod_ff     <= mod_in;
      prod_ff    <= prod_in;
      rd_addr_ff <= rd_addr_in;
      y_ff       <= y_in;
      pwm_ff     <= pwm_in;
   end

   // delay memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         delay_mem[clr_ptr_ff] <= '0;
      end else if (ctrl.op == OP_WRITE) begin
         delay_mem[wp_ff] <= wr_data;
      end
      if (ctrl.op == OP_READ) begin
         delayed_ff <= delay_mem[rd_addr_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_level     = pwm_ff;
   assign status.clear_busy = clr_busy_ff;
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

### design/modulated_delay_feedback_effect_core.sv
// flanger core top level: lfo-modulated feedback delay on a 12-bit converter sample
// depends on mdfe_pkg, mdfe_if, mdfe_seq and mdfe_dp
//
// req_if carries one converter sample per transaction (valid/ready); rsp_if returns
// one 8-bit pwm level per sample, in order. csr_* writes one of four registers
// (lfo step, modulation depth, feedback gain, wet gain) whenever csr_wr_en is high.
// each transaction runs a 14-step microprogram that shares one 32x16 multiplier
// (five products) and the delay memory: the result shows on rsp_if once the output
// step has run, and a new sample is taken only after the previous one has passed
// that step. the finished level sits in an output register, so the next sample is
// accepted and worked on while the previous level waits; that sample then parks
// before its output step until rsp_if.ready takes the waiting level.
// reset is synchronous; afterwards the delay memory is cleared one entry a cycle,
// with req_if.ready low; csr writes are taken meanwhile.
module modulated_delay_feedback_effect_core #(
   parameter int DELAY_DEPTH     = 88,
   parameter int SINE_TABLE_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   mdfe_req_if.sink                            req_if,
   mdfe_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [mdfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdfe_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mdfe_pkg::*;

   mdfe_csr_type    csr_ff;
   mdfe_csr_type    csr_in;
   mdfe_ctrl_type   ctrl;
   mdfe_status_type status;

   // register writes, values masked to field width
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (mdfe_csr_idx_type'(csr_index))
            CSR_LFO_STEP:      csr_in.lfo_step      = csr_wdata[PHASE_W-1:0];
            CSR_MOD_DEPTH:     csr_in.mod_depth     = csr_wdata[GAIN_W-1:0];
            CSR_FEEDBACK_GAIN: csr_in.feedback_gain = csr_wdata[GAIN_W-1:0];
            CSR_WET_GAIN:      csr_in.wet_gain      = csr_wdata[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // step counter and control store
   mdfe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // arithmetic, lfo, delay memory and output register
   mdfe_dp #(
      .DELAY_DEPTH     (DELAY_DEPTH),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .csr            (csr_ff),
      .req_adc_sample (req_if.adc_sample),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_pwm_level  (rsp_if.pwm_level),
      .status         (status)
   );

endmodule
